FILE: src/double_ended_queue_macros.svh
// Assertion macros shared by the deque modules.
// Depends on nothing; the using module must have ports named clock and reset.
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// The condition holds at every rising clock edge outside reset.
`define DQ_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("deque invariant violated");

// The consequent holds in the same cycle as the antecedent.
`define DQ_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque implication violated");

`endif

FILE: src/dq_pkg.sv
// Shared types and constants of the double-ended queue.
// Depends on nothing; used by all deque modules.
package dq_pkg;

   // Command codes as they arrive on the request channel.
   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_LIST       = 3'd4
   } op_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   localparam int DATA_W = 32;

   // Request queue between front and back; the depth is a power of two.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic               valid;
      op_type             op;
      logic signed [31:0] data;
   } queue_head_type;

endpackage

FILE: src/dq_front.sv
// Front part of the deque: takes requests, drops unused command codes,
// and holds decoded requests in a short queue. Depends on dq_pkg.
`include "double_ended_queue_macros.svh"

module dq_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [2:0]            req_command,
   input  logic signed [31:0]    req_data_in,
   input  logic                  take,
   output dq_pkg::queue_head_type head
);

   dq_pkg::queue_head_type        entry_ff [dq_pkg::QUEUE_DEPTH];
   logic [dq_pkg::QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [dq_pkg::QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [dq_pkg::QUEUE_CW-1:0]   fill_ff, fill_in;
   logic                          code_ok;
   logic                          enq;
   dq_pkg::op_type                op_dec;

   always_comb begin
      code_ok = 1'b1;
      op_dec  = dq_pkg::OP_PUSH_FRONT;
      case (req_command)
         dq_pkg::OP_PUSH_FRONT: op_dec = dq_pkg::OP_PUSH_FRONT;
         dq_pkg::OP_PUSH_BACK:  op_dec = dq_pkg::OP_PUSH_BACK;
         dq_pkg::OP_POP_FRONT:  op_dec = dq_pkg::OP_POP_FRONT;
         dq_pkg::OP_POP_BACK:   op_dec = dq_pkg::OP_POP_BACK;
         dq_pkg::OP_LIST:       op_dec = dq_pkg::OP_LIST;
         default:               code_ok = 1'b0;
      endcase
   end

   assign busy = (fill_ff == dq_pkg::QUEUE_CW'(dq_pkg::QUEUE_DEPTH));
   // Unused codes are accepted and dropped here.
   assign enq  = start && !busy && code_ok;

   always_comb begin
      wr_ptr_in = enq  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({enq, take})
         2'b10:   fill_in = fill_ff + 1'b1;
         2'b01:   fill_in = fill_ff - 1'b1;
         default: fill_in = fill_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         entry_ff[wr_ptr_ff].valid <= 1'b1;
         entry_ff[wr_ptr_ff].op    <= op_dec;
         entry_ff[wr_ptr_ff].data  <= req_data_in;
      end
   end

   always_comb begin
      head       = entry_ff[rd_ptr_ff];
      head.valid = (fill_ff != '0);
   end

   `DQ_ASSERT_ALWAYS(fill_in_range, fill_ff <= dq_pkg::QUEUE_CW'(dq_pkg::QUEUE_DEPTH))
   `DQ_ASSERT_IMPLY(take_needs_entry, take, fill_ff != '0)

endmodule

FILE: src/dq_back.sv
// Back part of the deque: ring store, front pointer, element count and the
// list sequencer; drives the result channel. Depends on dq_pkg.
`include "double_ended_queue_macros.svh"

module dq_back #(
   parameter int CAPACITY = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dq_pkg::queue_head_type head,
   output logic                   take,
   output logic                   rsp_strobe,
   output logic [1:0]             rsp_status,
   output logic signed [31:0]     rsp_data_out,
   output logic                   rsp_last
);

   localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int SUM_W = $clog2(2 * CAPACITY);

   typedef enum logic {ST_RUN, ST_LIST} state_type;

   state_type          state_ff, state_in;
   logic [PTR_W-1:0]   front_ff, front_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [PTR_W-1:0]   list_ptr_ff, list_ptr_in;
   logic [CNT_W-1:0]   left_ff, left_in;
   logic               strobe_ff, strobe_in;
   logic [1:0]         status_ff, status_in;
   logic               last_ff, last_in;
   logic               list_ff, list_in;

   logic signed [31:0] store_ff [CAPACITY];
   logic signed [31:0] rd_data_ff;
   logic               wr_en;
   logic [PTR_W-1:0]   wr_addr;
   logic [PTR_W-1:0]   rd_addr;

   logic               empty, full;
   logic [PTR_W-1:0]   front_inc, front_dec, back_idx;
   logic [SUM_W-1:0]   back_sum;

   function automatic logic [PTR_W-1:0] ring_inc(input logic [PTR_W-1:0] p);
      ring_inc = (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
   endfunction

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign front_inc = ring_inc(front_ff);
   assign front_dec = (front_ff == '0) ? PTR_W'(CAPACITY - 1) : front_ff - 1'b1;
   // Front plus count stays below twice the capacity when not full.
   assign back_sum  = SUM_W'(front_ff) + SUM_W'(count_ff);
   assign back_idx  = (back_sum >= SUM_W'(CAPACITY)) ?
                      PTR_W'(back_sum - SUM_W'(CAPACITY)) : PTR_W'(back_sum);

   always_comb begin
      state_in    = state_ff;
      front_in    = front_ff;
      count_in    = count_ff;
      list_ptr_in = list_ptr_ff;
      left_in     = left_ff;
      strobe_in   = 1'b0;
      status_in   = dq_pkg::STATUS_OK;
      last_in     = 1'b1;
      list_in     = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = front_dec;
      rd_addr     = list_ptr_ff;
      take        = 1'b0;
      case (state_ff)
         ST_RUN: begin
            if (head.valid) begin
               take = 1'b1;
               case (head.op)
                  dq_pkg::OP_PUSH_FRONT: begin
                     strobe_in = 1'b1;
                     if (full) begin
                        status_in = dq_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = front_dec;
                        front_in = front_dec;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  dq_pkg::OP_PUSH_BACK: begin
                     strobe_in = 1'b1;
                     if (full) begin
                        status_in = dq_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = back_idx;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  dq_pkg::OP_POP_FRONT: begin
                     strobe_in = 1'b1;
                     if (empty) begin
                        status_in = dq_pkg::STATUS_EMPTY;
                     end else begin
                        front_in = front_inc;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  dq_pkg::OP_POP_BACK: begin
                     strobe_in = 1'b1;
                     if (empty) begin
                        status_in = dq_pkg::STATUS_EMPTY;
                     end else begin
                        count_in = count_ff - 1'b1;
                     end
                  end
                  dq_pkg::OP_LIST: begin
                     strobe_in = 1'b1;
                     if (empty) begin
                        status_in = dq_pkg::STATUS_EMPTY;
                     end else begin
                        rd_addr     = front_ff;
                        list_in     = 1'b1;
                        last_in     = (count_ff == CNT_W'(1));
                        list_ptr_in = front_inc;
                        left_in     = count_ff - 1'b1;
                        if (count_ff != CNT_W'(1)) begin
                           state_in = ST_LIST;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_LIST: begin
            rd_addr     = list_ptr_ff;
            strobe_in   = 1'b1;
            list_in     = 1'b1;
            last_in     = (left_ff == CNT_W'(1));
            list_ptr_in = ring_inc(list_ptr_ff);
            left_in     = left_ff - 1'b1;
            if (left_ff == CNT_W'(1)) begin
               state_in = ST_RUN;
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_RUN;
         front_ff  <= '0;
         count_ff  <= '0;
         left_ff   <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         front_ff  <= front_in;
         count_ff  <= count_in;
         left_ff   <= left_in;
         strobe_ff <= strobe_in;
      end
      list_ptr_ff <= list_ptr_in;
      status_ff   <= status_in;
      last_ff     <= last_in;
      list_ff     <= list_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= head.data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rsp_strobe   = strobe_ff;
   assign rsp_status   = status_ff;
   assign rsp_last     = last_ff;
   assign rsp_data_out = list_ff ? rd_data_ff : '0;

   `DQ_ASSERT_ALWAYS(count_in_range, count_ff <= CNT_W'(CAPACITY))
   `DQ_ASSERT_IMPLY(list_has_work, state_ff == ST_LIST, left_ff != '0)
   `DQ_ASSERT_IMPLY(error_is_last, strobe_ff && (status_ff != dq_pkg::STATUS_OK), last_ff)
   `DQ_ASSERT_IMPLY(no_write_when_full, wr_en, !full)

endmodule

FILE: src/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed 32-bit words.
// Depends on dq_pkg, dq_front and dq_back.
//
// Usage: a request (command and data) is accepted at a rising edge where
// start is high and busy is low. Commands are push front, push back, pop
// front, pop back and list; unused command codes are accepted and dropped
// without any result. Each result appears for exactly one cycle with
// rsp_strobe high; the receiver cannot hold results off.
// The result of a push or pop passes through the request queue and then the
// back part, whose outputs are registered; a request waits in the queue while
// a list is in progress.
// Throughput: one push or pop per cycle while no list is in progress. A list
// of N elements returns N results, one per cycle, from the single read port of
// the ring store; an empty list returns one result with status empty.
// A two-entry request queue sits between the decoding front part and the
// executing back part; busy is high while that queue is full, so requests
// back up only behind a list in progress.
// Reset empties the deque and the request queue; the ring store itself is not
// cleared, since an entry is read only after a push has written it.
module double_ended_queue #(
   parameter int CAPACITY = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_command,
   input  logic signed [31:0] req_data_in,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic signed [31:0] rsp_data_out,
   output logic               rsp_last
);

   // Head of the request queue as the back part sees it.
   dq_pkg::queue_head_type head;
   // The back part removes the head request in the cycle it executes it.
   logic take;

   dq_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_data_in (req_data_in),
      .take        (take),
      .head        (head)
   );

   dq_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .take         (take),
      .rsp_strobe   (rsp_strobe),
      .rsp_status   (rsp_status),
      .rsp_data_out (rsp_data_out),
      .rsp_last     (rsp_last)
   );

endmodule

FILE: tb/sv/tb_double_ended_queue.sv
`timescale 1ns / 1ps
// Self-checking testbench for the bounded double-ended queue (double_ended_queue).
// Depends on dq_pkg for command codes and status values, and on double_ended_queue.
module tb_double_ended_queue;
   import dq_pkg::*;

   localparam int DEPTH = 32;

   // Command codes beyond list are accepted and dropped without a response.
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   // One response as it should appear on the rsp_ ports.
   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] data;
      logic               last;
   } response_t;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [2:0]         req_command;
   logic signed [31:0] req_data_in;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_data_out;
   logic               rsp_last;

   // Mirror of the deque contents, updated when a request is accepted.
   logic signed [31:0] mirror_store [DEPTH];
   int                 mirror_front = 0;
   int                 mirror_count = 0;

   // Responses still owed by the block, oldest first.
   response_t          owed_responses [$];
   int                 mismatch_count = 0;

   // Requests left in the current burst of the sender; zero forces a gap.
   int                 burst_left = 0;

   double_ended_queue #(
      .CAPACITY(DEPTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_command (req_command),
      .req_data_in (req_data_in),
      .rsp_strobe  (rsp_strobe),
      .rsp_status  (rsp_status),
      .rsp_data_out(rsp_data_out),
      .rsp_last    (rsp_last)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic void owe(input logic [1:0] status, input logic signed [31:0] data,
                               input logic last);
      owed_responses.push_back(response_t'{status, data, last});
   endfunction

   // Applies one accepted request to the mirror and queues the responses it causes.
   // A push goes into the slot just ahead of the front or just past the back;
   // a list walks the ring from the front and marks the final element.
   function automatic void deque_apply(input logic [2:0] code, input logic signed [31:0] value);
      int slot;
      case (code)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (mirror_count >= DEPTH) begin
               owe(STATUS_FULL, '0, 1'b1);
            end else begin
               if (code == OP_PUSH_FRONT) begin
                  mirror_front = (mirror_front + DEPTH - 1) % DEPTH;
                  slot = mirror_front;
               end else begin
                  slot = (mirror_front + mirror_count) % DEPTH;
               end
               mirror_store[slot] = value;
               mirror_count++;
               owe(STATUS_OK, '0, 1'b1);
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (mirror_count == 0) begin
               owe(STATUS_EMPTY, '0, 1'b1);
            end else begin
               if (code == OP_POP_FRONT) begin
                  mirror_front = (mirror_front + 1) % DEPTH;
               end
               mirror_count--;
               owe(STATUS_OK, '0, 1'b1);
            end
         end
         OP_LIST: begin
            if (mirror_count == 0) begin
               owe(STATUS_EMPTY, '0, 1'b1);
            end else begin
               for (slot = 0; slot < mirror_count; slot++) begin
                  owe(STATUS_OK, mirror_store[(mirror_front + slot) % DEPTH],
                      slot == mirror_count - 1);
               end
            end
         end
         default: ;
      endcase
   endfunction

   // Data values lean toward the extremes now and then; otherwise any word.
   function automatic logic signed [31:0] random_word();
      case ($urandom_range(0, 15))
         0: return 32'sh7FFF_FFFF;
         1: return 32'sh8000_0000;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Draws a command; grow favors pushes, otherwise pops dominate. Lists and
   // spare codes show up at a fixed small rate either way.
   function automatic logic [2:0] pick_command(input bit grow);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         return 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end else if (roll < 14) begin
         return OP_LIST;
      end else if (grow ? (roll < 74) : (roll < 34)) begin
         return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      end else begin
         return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      end
   endfunction

   // Sends one request. The caller is always just past a falling edge. The
   // sender works in bursts: when a burst runs out, start drops for a random
   // number of cycles and a new burst length is drawn. Long bursts give
   // stretches of back-to-back requests. Start is left high on return, so the
   // next request in the burst follows without a bubble.
   task automatic send_request(input logic [2:0] code, input logic signed [31:0] value);
      if (burst_left == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 8)
                                                  : $urandom_range(20, 60);
      end
      burst_left--;
      start       <= 1'b1;
      req_command <= code;
      req_data_in <= value;
      // The request is taken at the first rising edge that sees busy low.
      @(posedge clock);
      while (busy) @(posedge clock);
      deque_apply(code, value);
      @(negedge clock);
   endtask

   // Every strobed response is matched against the oldest owed one.
   always @(posedge clock) begin : check_responses
      response_t want;
      if (!reset && rsp_strobe) begin
         if (owed_responses.size() == 0) begin
            $error("unexpected response: status %0d data %0d last %0d",
                   rsp_status, rsp_data_out, rsp_last);
            mismatch_count++;
         end else begin
            want = owed_responses.pop_front();
            if (rsp_status !== want.status) begin
               $error("rsp_status: expected %0d, actual %0d", want.status, rsp_status);
               mismatch_count++;
            end
            if (rsp_data_out !== want.data) begin
               $error("rsp_data_out: expected %0d, actual %0d", want.data, rsp_data_out);
               mismatch_count++;
            end
            if (rsp_last !== want.last) begin
               $error("rsp_last: expected %0d, actual %0d", want.last, rsp_last);
               mismatch_count++;
            end
         end
      end
   end

   // An empty deque answers list and both pops with status empty, and the
   // spare command codes are dropped without any response.
   task automatic test_empty_deque();
      logic [2:0] code;
      send_request(OP_LIST, random_word());
      send_request(OP_POP_FRONT, random_word());
      send_request(OP_POP_BACK, random_word());
      for (code = CMD_SPARE_FIRST; code != 3'd0; code++) begin
         send_request(code, random_word());
      end
   endtask

   // Extreme values pushed at both ends, listed, and popped from both ends
   // until the deque is empty again; a final pop checks the empty status.
   task automatic test_value_extremes();
      send_request(OP_PUSH_BACK, 32'sh7FFF_FFFF);
      send_request(OP_PUSH_FRONT, 32'sh8000_0000);
      send_request(OP_PUSH_BACK, '0);
      send_request(OP_PUSH_FRONT, '1);
      send_request(OP_PUSH_BACK, 32'sh5555_5555);
      send_request(OP_PUSH_FRONT, 32'shAAAA_AAAA);
      send_request(OP_LIST, '0);
      send_request(OP_POP_BACK, '0);
      send_request(OP_POP_FRONT, '0);
      send_request(OP_LIST, '0);
      send_request(OP_POP_FRONT, '0);
      send_request(OP_POP_BACK, '0);
      send_request(OP_POP_FRONT, '0);
      send_request(OP_POP_BACK, '0);
      send_request(OP_POP_BACK, '0);
      send_request(OP_LIST, '0);
   endtask

   // Fills the deque to capacity from random ends, pushes at both ends while
   // full, lists the full ring, then drains it with a list halfway down.
   task automatic test_full_deque();
      while (mirror_count < DEPTH) begin
         send_request($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, random_word());
      end
      send_request(OP_PUSH_FRONT, random_word());
      send_request(OP_PUSH_BACK, random_word());
      send_request(OP_LIST, random_word());
      while (mirror_count > 0) begin
         send_request($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, random_word());
         if (mirror_count == DEPTH / 2) begin
            send_request(OP_LIST, random_word());
         end
      end
      send_request(OP_LIST, random_word());
   endtask

   // Random traffic in phases. Each phase picks a fill level to head for:
   // empty, full, or somewhere between. Heading for empty or full keeps
   // pushing or popping past the edge, so the full and empty statuses come up
   // often, and the front pointer wraps around the ring many times.
   task automatic test_random_traffic(input int request_total);
      int target;
      int phase_left;
      while (request_total > 0) begin
         case ($urandom_range(0, 2))
            0: target = 0;
            1: target = DEPTH;
            default: target = $urandom_range(1, DEPTH - 1);
         endcase
         phase_left = $urandom_range(20, 40);
         while (phase_left > 0 && request_total > 0) begin
            send_request(pick_command(mirror_count < target || target == DEPTH),
                         random_word());
            phase_left--;
            request_total--;
         end
      end
   endtask

   initial begin : run_tests
      int waited;
      reset       = 1'b1;
      start       = 1'b0;
      req_command = OP_PUSH_FRONT;
      req_data_in = '0;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_empty_deque();
      test_value_extremes();
      test_full_deque();
      test_random_traffic(280);
      start <= 1'b0;

      // Wait for the owed responses, then wait on past them so that a stray
      // extra response would still be caught.
      waited = 0;
      while (owed_responses.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (owed_responses.size() != 0) begin
         $error("%0d expected responses never arrived", owed_responses.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // A hung handshake ends the run here, far beyond the slowest correct run.
   initial begin : watchdog
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+src
src/dq_pkg.sv
src/dq_front.sv
src/dq_back.sv
src/double_ended_queue.sv
tb/sv/tb_double_ended_queue.sv
